// ===== rtl/core/bfea_pkg.sv =====
// ----------------------------------------------------------------------------
// bfea_pkg
// Shared types and codes for the best-fit extent allocator.
// ----------------------------------------------------------------------------
package bfea_pkg;

  localparam int FIELD_W = 23;
  localparam int NEED_W  = 33;  // rounded length can reach 2^31 at wide alignments

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_CARVE,
    WR_MOVE,
    WR_LOWER,
    WR_UPPER,
    WR_APPEND,
    WR_SHIFT
  } wr_e;

  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    shift_init;
    logic    issue;
    logic    eval;
    logic    rd_last;
    wr_e     wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    free_sub;
    logic    free_add;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic zero_len;
    logic out_range;
    logic scan_done;
    logic best_found;
    logic carve;
    logic low_found;
    logic up_found;
    logic overlap;
    logic table_full;
  } stat_t;

endpackage

// ===== rtl/core/bfea_ram.sv =====
// ----------------------------------------------------------------------------
// bfea_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfea_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/bfea_datapath.sv =====
// ----------------------------------------------------------------------------
// bfea_datapath
// Extent table, scan compare, merge arithmetic, counters and result register.
// ----------------------------------------------------------------------------
module bfea_datapath #(
  parameter int              MAX_EXTENTS = 64,
  parameter longint unsigned ARENA_BYTES = 64'd4194304
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [4:0]                   cfg_data_i,
  input  logic                         in_action_i,
  input  logic [bfea_pkg::FIELD_W-1:0] in_start_i,
  input  logic [bfea_pkg::FIELD_W-1:0] in_length_i,
  input  bfea_pkg::cmd_t               cmd_i,
  output bfea_pkg::stat_t              stat_o,
  output logic [bfea_pkg::FIELD_W-1:0] blk_start_o,
  output logic [bfea_pkg::FIELD_W-1:0] blk_len_o,
  output logic [bfea_pkg::FIELD_W-1:0] free_bytes_o
);

  localparam int FW = bfea_pkg::FIELD_W;
  localparam int NW = bfea_pkg::NEED_W;
  localparam int AW = $clog2(ARENA_BYTES + 64'd1);
  localparam int EW = (AW > FW) ? AW : FW;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  localparam logic [EW-1:0] ArenaLen = EW'(ARENA_BYTES);
  localparam logic [EW:0]   ArenaEnd = (EW + 1)'(ARENA_BYTES);

  // control state
  logic [4:0]    align_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [EW-1:0] free_q, free_d;
  logic          iss_q, iss_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          hit_q, hit_d;
  logic          best_vld_q, best_vld_d;
  logic          low_vld_q, low_vld_d;
  logic          up_vld_q, up_vld_d;
  logic          ovl_q, ovl_d;

  // payload
  logic          action_q;
  logic          dir_dn_q, dir_dn_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [EW-1:0] req_start_q, req_len_q;
  logic [EW:0]   req_end_q;
  logic [NW-1:0] need_q;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [EW-1:0] best_start_q, best_start_d, best_len_q, best_len_d;
  logic [IW-1:0] low_idx_q, low_idx_d, up_idx_q, up_idx_d;
  logic [EW-1:0] low_start_q, low_start_d, low_len_q, low_len_d, up_len_q, up_len_d;

  // table access
  logic            we;
  logic [IW-1:0]   waddr, raddr;
  logic [2*EW-1:0] wdata, rdata;
  logic [EW-1:0]   rd_start, rd_len, rd_end;

  // alignment round-up of the request
  logic [NW-1:0] amask, need_d;
  assign amask  = (NW'(1) << align_q) - NW'(1);
  assign need_d = (NW'(in_length_i) + amask) & ~amask;

  assign rd_start = rdata[2*EW-1:EW];
  assign rd_len   = rdata[EW-1:0];
  assign rd_end   = rd_start + rd_len;

  logic eval_on, issue_on;
  logic fit_exact, fit_more, better;
  logic is_low, is_up, is_ovl;

  assign eval_on   = cmd_i.eval && iss_q && !hit_q;
  assign issue_on  = cmd_i.issue && (rem_q != '0) && !hit_q;
  assign fit_exact = need_q == NW'(rd_len);
  assign fit_more  = need_q < NW'(rd_len);
  assign better    = !best_vld_q || (rd_len < best_len_q) ||
                     ((rd_len == best_len_q) && (rd_start < best_start_q));
  assign is_low    = req_end_q - (EW + 1)'(req_len_q) == (EW + 1)'(rd_end);
  assign is_up     = !is_low && (req_end_q == (EW + 1)'(rd_start));
  assign is_ovl    = !is_low && !is_up && (req_end_q > (EW + 1)'(rd_start)) &&
                     ((EW + 1)'(req_start_q) < (EW + 1)'(rd_end));

  always_comb begin
    iss_d        = issue_on;
    rem_d        = rem_q;
    ptr_d        = ptr_q;
    idx_d        = idx_q;
    dir_dn_d     = dir_dn_q;
    hit_d        = hit_q;
    best_vld_d   = best_vld_q;
    best_idx_d   = best_idx_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    low_vld_d    = low_vld_q;
    low_idx_d    = low_idx_q;
    low_start_d  = low_start_q;
    low_len_d    = low_len_q;
    up_vld_d     = up_vld_q;
    up_idx_d     = up_idx_q;
    up_len_d     = up_len_q;
    ovl_d        = ovl_q;

    if (cmd_i.load) begin
      hit_d      = 1'b0;
      best_vld_d = 1'b0;
      low_vld_d  = 1'b0;
      up_vld_d   = 1'b0;
      ovl_d      = 1'b0;
    end

    if (cmd_i.scan_init) begin
      dir_dn_d = !action_q;
      rem_d    = cnt_q;
      ptr_d    = action_q ? '0 : IW'(cnt_q - CW'(1));
    end

    if (cmd_i.shift_init) begin
      dir_dn_d = 1'b0;
      ptr_d    = up_idx_q + IW'(1);
      rem_d    = cnt_q - CW'(1) - CW'(up_idx_q);
    end

    if (issue_on) begin
      idx_d = ptr_q;
      rem_d = rem_q - CW'(1);
      ptr_d = dir_dn_q ? ptr_q - IW'(1) : ptr_q + IW'(1);
    end

    if (eval_on) begin
      if (!action_q) begin
        if (fit_exact) begin
          hit_d        = 1'b1;
          best_vld_d   = 1'b1;
          best_idx_d   = idx_q;
          best_start_d = rd_start;
          best_len_d   = rd_len;
        end else if (fit_more && better) begin
          best_vld_d   = 1'b1;
          best_idx_d   = idx_q;
          best_start_d = rd_start;
          best_len_d   = rd_len;
        end
      end else begin
        if (is_low && !low_vld_q) begin
          low_vld_d   = 1'b1;
          low_idx_d   = idx_q;
          low_start_d = rd_start;
          low_len_d   = rd_len;
        end
        if (is_up && !up_vld_q) begin
          up_vld_d = 1'b1;
          up_idx_d = idx_q;
          up_len_d = rd_len;
        end
        if (is_ovl) begin
          ovl_d = 1'b1;
        end
      end
    end
  end

  // table write port
  always_comb begin
    we    = 1'b1;
    waddr = '0;
    wdata = '0;
    case (cmd_i.wr)
      bfea_pkg::WR_INIT: begin
        wdata = {{EW{1'b0}}, ArenaLen};
      end
      bfea_pkg::WR_CARVE: begin
        waddr = best_idx_q;
        wdata = {best_start_q + need_q[EW-1:0], best_len_q - need_q[EW-1:0]};
      end
      bfea_pkg::WR_MOVE: begin
        waddr = best_idx_q;
        wdata = rdata;
      end
      bfea_pkg::WR_LOWER: begin
        waddr = low_idx_q;
        wdata = {low_start_q, low_len_q + req_len_q + (up_vld_q ? up_len_q : '0)};
      end
      bfea_pkg::WR_UPPER: begin
        waddr = up_idx_q;
        wdata = {req_start_q, up_len_q + req_len_q};
      end
      bfea_pkg::WR_APPEND: begin
        waddr = IW'(cnt_q);
        wdata = {req_start_q, req_len_q};
      end
      bfea_pkg::WR_SHIFT: begin
        we    = iss_q;
        waddr = idx_q - IW'(1);
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr = cmd_i.rd_last ? IW'(cnt_q - CW'(1)) : ptr_q;

  bfea_ram #(
    .WIDTH(2 * EW),
    .DEPTH(MAX_EXTENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    cnt_d  = cnt_q;
    free_d = free_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.free_sub) begin
      free_d = free_q - need_q[EW-1:0];
    end else if (cmd_i.free_add) begin
      free_d = free_q + req_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q    <= 5'd6;
      cnt_q      <= CW'(1);
      free_q     <= ArenaLen;
      iss_q      <= 1'b0;
      rem_q      <= '0;
      hit_q      <= 1'b0;
      best_vld_q <= 1'b0;
      low_vld_q  <= 1'b0;
      up_vld_q   <= 1'b0;
      ovl_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        align_q <= cfg_data_i;
      end
      cnt_q      <= cnt_d;
      free_q     <= free_d;
      iss_q      <= iss_d;
      rem_q      <= rem_d;
      hit_q      <= hit_d;
      best_vld_q <= best_vld_d;
      low_vld_q  <= low_vld_d;
      up_vld_q   <= up_vld_d;
      ovl_q      <= ovl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q    <= in_action_i;
      req_start_q <= EW'(in_start_i);
      req_len_q   <= EW'(in_length_i);
      req_end_q   <= (EW + 1)'(in_start_i) + (EW + 1)'(in_length_i);
      need_q      <= need_d;
    end
    dir_dn_q     <= dir_dn_d;
    ptr_q        <= ptr_d;
    idx_q        <= idx_d;
    best_idx_q   <= best_idx_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    low_idx_q    <= low_idx_d;
    low_start_q  <= low_start_d;
    low_len_q    <= low_len_d;
    up_idx_q     <= up_idx_d;
    up_len_q     <= up_len_d;
    if (cmd_i.out_load) begin
      if (cmd_i.out_status == bfea_pkg::ST_OK && !action_q) begin
        blk_start_o <= best_start_q[FW-1:0];
        blk_len_o   <= need_q[FW-1:0];
      end else begin
        blk_start_o <= '0;
        blk_len_o   <= '0;
      end
      free_bytes_o <= free_q[FW-1:0];
    end
  end

  assign stat_o.is_release = action_q;
  assign stat_o.zero_len   = req_len_q == '0;
  assign stat_o.out_range  = req_end_q > ArenaEnd;
  assign stat_o.scan_done  = hit_q || ((rem_q == '0) && !iss_q);
  assign stat_o.best_found = best_vld_q;
  assign stat_o.carve      = NW'(best_len_q) != need_q;
  assign stat_o.low_found  = low_vld_q;
  assign stat_o.up_found   = up_vld_q;
  assign stat_o.overlap    = ovl_q;
  assign stat_o.table_full = cnt_q == CW'(MAX_EXTENTS);

endmodule

// ===== rtl/core/bfea_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfea_ctrl
// Request sequencer: check, scan, update, and result handoff.
// ----------------------------------------------------------------------------
module bfea_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bfea_pkg::status_e out_status_o,
  input  bfea_pkg::stat_t stat_i,
  output bfea_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SHIFT,
    S_RESULT
  } state_e;

  state_e            state_q, state_d;
  bfea_pkg::status_e stat_q, stat_d;
  bfea_pkg::status_e res_q, res_d;
  logic              out_vld_q, out_vld_d;

  always_comb begin
    state_d   = state_q;
    stat_d    = stat_q;
    res_d     = res_q;
    cmd_o     = '0;
    cmd_o.wr  = bfea_pkg::WR_NONE;
    cmd_o.out_status = stat_q;
    out_vld_d = out_vld_q && !out_ready_i;

    unique case (state_q)
      S_INIT: begin
        cmd_o.wr = bfea_pkg::WR_INIT;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.zero_len) begin
          stat_d  = bfea_pkg::ST_ZERO;
          state_d = S_RESULT;
        end else if (stat_i.is_release && stat_i.out_range) begin
          stat_d  = bfea_pkg::ST_RANGE;
          state_d = S_RESULT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        cmd_o.eval  = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        stat_d  = bfea_pkg::ST_OK;
        state_d = S_RESULT;
        if (!stat_i.is_release) begin
          if (!stat_i.best_found) begin
            stat_d = bfea_pkg::ST_NOFIT;
          end else if (stat_i.carve) begin
            cmd_o.wr       = bfea_pkg::WR_CARVE;
            cmd_o.free_sub = 1'b1;
          end else begin
            state_d = S_MOVE_RD;
          end
        end else if (stat_i.overlap) begin
          stat_d = bfea_pkg::ST_OVERLAP;
        end else if (stat_i.low_found) begin
          cmd_o.wr       = bfea_pkg::WR_LOWER;
          cmd_o.free_add = 1'b1;
          if (stat_i.up_found) begin
            // bridged two extents: drop the upper one, close the gap
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT;
          end
        end else if (stat_i.up_found) begin
          cmd_o.wr       = bfea_pkg::WR_UPPER;
          cmd_o.free_add = 1'b1;
        end else if (stat_i.table_full) begin
          stat_d = bfea_pkg::ST_FULL;
        end else begin
          cmd_o.wr       = bfea_pkg::WR_APPEND;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.free_add = 1'b1;
        end
      end
      S_MOVE_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.wr       = bfea_pkg::WR_MOVE;
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.free_sub = 1'b1;
        state_d        = S_RESULT;
      end
      S_SHIFT: begin
        cmd_o.issue = 1'b1;
        cmd_o.wr    = bfea_pkg::WR_SHIFT;
        if (stat_i.scan_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_vld_d      = 1'b1;
          res_d          = stat_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      stat_q    <= bfea_pkg::ST_OK;
      res_q     <= bfea_pkg::ST_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      stat_q    <= stat_d;
      res_q     <= res_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o   = state_q == S_IDLE;
  assign out_valid_o  = out_vld_q;
  assign out_status_o = res_q;

endmodule

// ===== rtl/core/best_fit_extent_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_extent_allocator_top
// Best-fit free-extent allocator with merge on release, one arena.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata / data (low bit up)                  | tuser
//  s_axis   | in  | request_start, request_length (48 b)        | action
//  m_axis   | out | alloc_start, alloc_len, free_bytes (72 b)   | status
//  cfg      | in  | align_log2 (5 b)                            | -
//
//  A request scans its N table entries, one entry read per cycle on the single
//  read port; an exact fit stops the scan early. Using up an extent adds the
//  move read and move write steps; a bridging release shifts down the M entries
//  above the removed one. After reset the init state seeds entry 0. The result
//  register frees the input side; a stalled result holds the next request at
//  its result step.
// ----------------------------------------------------------------------------
module best_fit_extent_allocator_top #(
  parameter int              MAX_EXTENTS = 64,
  parameter longint unsigned ARENA_BYTES = 64'd4194304
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // request_start, request_length, pad
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // alloc_start, alloc_len, free_bytes, pad
  output logic [2:0]  m_axis_tuser,   // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int FW = bfea_pkg::FIELD_W;

  bfea_pkg::cmd_t    cmd;
  bfea_pkg::stat_t   stat;
  bfea_pkg::status_e out_status;
  logic [FW-1:0]     blk_start, blk_len, free_bytes;

  assign cfg_ready_o = 1'b1;

  bfea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(out_status),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfea_datapath #(
    .MAX_EXTENTS(MAX_EXTENTS),
    .ARENA_BYTES(ARENA_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_action_i   (s_axis_tuser[0]),
    .in_start_i    (s_axis_tdata[FW-1:0]),
    .in_length_i   (s_axis_tdata[2*FW-1:FW]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .blk_start_o   (blk_start),
    .blk_len_o     (blk_len),
    .free_bytes_o  (free_bytes)
  );

  // status is held in the controller alongside the valid flag
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, free_bytes, blk_len, blk_start};

endmodule

// ===== verif/tb_best_fit_extent_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_extent_allocator_top
// Self-checking bench for the best-fit extent allocator. Requests are queued
// and their results predicted in order by a behavioral free-extent table.
// Covers error cases, merges, a full table and several alignments, under
// random source gaps and sink stalls, including one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_best_fit_extent_allocator_top;

  localparam int              NUM_EXT    = 64;
  localparam longint unsigned ARENA      = 64'd4194304;
  localparam int              IDLE_LIMIT = 20000;
  localparam int              DRAIN_WAIT = NUM_EXT * 2 + 40;

  typedef struct {
    logic        release_op;
    logic [22:0] start;
    logic [22:0] length;
  } request_t;

  typedef struct {
    bfea_pkg::status_e status;
    logic [22:0]       blk_start;
    logic [22:0]       blk_length;
    logic [22:0]       free_bytes;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = 5'd6;

  best_fit_extent_allocator_top #(
    .MAX_EXTENTS(NUM_EXT),
    .ARENA_BYTES(ARENA)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // free-extent table shadow
  longint unsigned ext_start[NUM_EXT];
  longint unsigned ext_len[NUM_EXT];
  int unsigned     ext_count;
  longint unsigned free_sum;
  logic [4:0]      align_sh;

  request_t        req_q[$];
  result_t         result_q[$];
  longint unsigned live_start[$];
  longint unsigned live_len[$];

  int unsigned errors = 0;
  int unsigned req_sent = 0;
  int unsigned res_seen = 0;
  int unsigned st_hits[6];
  int unsigned idle_cycles = 0;

  function automatic result_t allocator_step(request_t rq);
    result_t         r;
    longint unsigned alignv, need, len, s, e, es, ee;
    int              best, lower, upper, k;
    logic            hit;
    r = '{bfea_pkg::ST_OK, '0, '0, '0};
    len = rq.length;
    s = rq.start;
    if (len == 0) begin
      r.status = bfea_pkg::ST_ZERO;
    end else if (!rq.release_op) begin
      alignv = 64'd1 << align_sh;
      need = (len + alignv - 1) & ~(alignv - 1);
      best = -1;
      hit = 1'b0;
      for (int j = 0; j < ext_count; j++) begin
        k = ext_count - 1 - j;
        if (!hit && need <= ext_len[k]) begin
          if (need == ext_len[k]) begin
            best = k;
            hit = 1'b1;
          end else if (best < 0 || ext_len[k] < ext_len[best] ||
                       (ext_len[k] == ext_len[best] && ext_start[k] < ext_start[best])) begin
            best = k;
          end
        end
      end
      if (best < 0) begin
        r.status = bfea_pkg::ST_NOFIT;
      end else begin
        r.blk_start = ext_start[best];
        r.blk_length = need;
        if (ext_len[best] > need) begin
          ext_start[best] += need;
          ext_len[best] -= need;
        end else begin
          ext_start[best] = ext_start[ext_count-1];
          ext_len[best] = ext_len[ext_count-1];
          ext_count--;
        end
        free_sum -= need;
      end
    end else begin
      e = s + len;
      lower = -1;
      upper = -1;
      if (e > ARENA) begin
        r.status = bfea_pkg::ST_RANGE;
      end else begin
        for (int i = 0; i < ext_count; i++) begin
          es = ext_start[i];
          ee = es + ext_len[i];
          if (s == ee) begin
            if (lower < 0) lower = i;
          end else if (e == es) begin
            if (upper < 0) upper = i;
          end else if (e > es && s < ee) begin
            r.status = bfea_pkg::ST_OVERLAP;
          end
        end
        if (r.status == bfea_pkg::ST_OK) begin
          if (lower >= 0) begin
            ext_len[lower] += len;
            if (upper >= 0) begin
              ext_len[lower] += ext_len[upper];
              for (int i = upper; i + 1 < ext_count; i++) begin
                ext_start[i] = ext_start[i+1];
                ext_len[i] = ext_len[i+1];
              end
              ext_count--;
            end
          end else if (upper >= 0) begin
            ext_len[upper] += len;
            ext_start[upper] = s;
          end else if (ext_count >= NUM_EXT) begin
            r.status = bfea_pkg::ST_FULL;
          end else begin
            ext_start[ext_count] = s;
            ext_len[ext_count] = len;
            ext_count++;
          end
          if (r.status == bfea_pkg::ST_OK) free_sum += len;
        end
      end
    end
    r.free_bytes = free_sum[22:0];
    return r;
  endfunction

  // queue one request, predict it and track live blocks
  task automatic push_req(logic rel, longint unsigned s, longint unsigned l);
    request_t rq;
    result_t  r;
    rq.release_op = rel;
    rq.start = s[22:0];
    rq.length = l[22:0];
    r = allocator_step(rq);
    req_q.insert(req_q.size(), rq);
    result_q.insert(result_q.size(), r);
    if (!rel && r.status == bfea_pkg::ST_OK) begin
      live_start.insert(live_start.size(), r.blk_start);
      live_len.insert(live_len.size(), r.blk_length);
    end
  endtask

  task automatic release_live(int idx);
    push_req(1'b1, live_start[idx], live_len[idx]);
    live_start.delete(idx);
    live_len.delete(idx);
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_align(logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    align_sh = v;
  endtask

  task automatic random_phase(int n);
    int unsigned sel, idx;
    longint unsigned l, h;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 45 || live_start.size() == 0) begin
        if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 23'h7FFFFF);
        else l = $urandom_range(1, 5000);
        push_req(1'b0, $urandom_range(0, 23'h7FFFFF), l);
      end else if (sel < 80) begin
        release_live($urandom_range(0, live_start.size() - 1));
      end else if (sel < 88) begin
        // give back the front part, keep the rest live
        idx = $urandom_range(0, live_start.size() - 1);
        h = live_len[idx] / 2;
        if (h == 0) begin
          release_live(idx);
        end else begin
          push_req(1'b1, live_start[idx], h);
          live_start[idx] += h;
          live_len[idx] -= h;
        end
      end else if (sel < 93) begin
        // release of a region already free or overlapping one
        idx = $urandom_range(0, live_start.size() - 1);
        push_req(1'b1, live_start[idx] + 1, live_len[idx]);
      end else begin
        push_req($urandom_range(0, 1), $urandom_range(0, 23'h7FFFFF),
                 $urandom_range(0, 23'h7FFFFF));
      end
    end
  endtask

  // stimulus and phase control
  initial begin
    logic [4:0] aligns[6];
    ext_start[0] = 0;
    ext_len[0] = ARENA;
    ext_count = 1;
    free_sum = ARENA;
    align_sh = 5'd6;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_align(5'd6);

    push_req(1'b0, 0, 0);
    push_req(1'b1, 0, 0);
    push_req(1'b0, 23'h7FFFFF, 1);
    push_req(1'b0, 0, 23'h7FFFFF);
    push_req(1'b1, 23'h7FFFFF, 1);
    push_req(1'b1, ARENA - 1, 2);
    push_req(1'b1, 0, 64);
    push_req(1'b0, 0, ARENA);
    push_req(1'b0, 0, 1);
    push_req(1'b1, 0, ARENA);
    push_req(1'b1, 100, 10);
    push_req(1'b0, 0, 63);
    push_req(1'b0, 0, 64);
    push_req(1'b0, 0, 65);
    push_req(1'b1, 64, 64);
    push_req(1'b1, 0, 64);
    push_req(1'b1, 128, 128);
    push_req(1'b1, 10, 20);
    live_start.delete();
    live_len.delete();
    wait_idle();

    // fragment the table until an append no longer fits
    for (int i = 0; i < 140; i++) push_req(1'b0, 0, 64);
    for (int i = 0; i < 66; i++) push_req(1'b1, i * 128, 64);
    for (int i = 66; i < 140; i++) push_req(1'b1, i * 128, 64);
    for (int i = 0; i < 66; i++) push_req(1'b1, i * 128 + 64, 64);
    for (int i = 66; i < 140; i++) push_req(1'b1, i * 128 + 64, 64);
    live_start.delete();
    live_len.delete();
    wait_idle();

    aligns = '{5'd21, 5'd0, 5'd31, 5'd6, 5'($urandom_range(7, 20)), 5'($urandom_range(0, 31))};
    foreach (aligns[p]) begin
      write_align(aligns[p]);
      random_phase(p == 2 ? 40 : 130);
      wait_idle();
    end

    $display("covered %0d requests, %0d results; ok %0d nofit %0d zero %0d range %0d",
             req_sent, res_seen, st_hits[0], st_hits[1], st_hits[2], st_hits[3]);
    $display("overlap %0d full %0d, alignments 0/6/21/31 and random, one long sink hold",
             st_hits[4], st_hits[5]);
    if (errors == 0) begin
      $display("PASS best_fit_extent_allocator_top");
    end else begin
      $display("FAIL best_fit_extent_allocator_top");
    end
    $finish;
  end

  // source: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    logic        fire;
    logic        offer;
    request_t    nx;
    fire = s_axis_tvalid && s_axis_tready;
    if (fire) begin
      void'(req_q.pop_front());
      req_sent++;
    end
    offer = 1'b0;
    if (gap_left != 0) begin
      gap_left--;
    end else if (req_q.size() != 0) begin
      offer = 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
      end else if (fire) begin
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          offer = (gap_left == 0);
        end
      end
    end
    if (offer) begin
      nx = req_q[0];
      s_axis_tdata <= {2'b00, nx.length, nx.start};
      s_axis_tuser <= nx.release_op;
    end
    s_axis_tvalid <= offer;
  end

  // sink: stall pattern plus one long hold-off
  int unsigned sink_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk_i) begin
    logic rdy;
    if (mode_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 400);
    end else begin
      mode_left--;
    end
    if (!hold_done && res_seen == 300) begin
      hold_done <= 1'b1;
      hold_left = 3000;
    end
    case (sink_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 3) != 0);
      2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = (mode_left[3:0] < 4'd6);
    endcase
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      res_seen++;
      if (m_axis_tuser < 6) st_hits[m_axis_tuser]++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat status %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        exp_r = result_q.pop_front();
        if (m_axis_tuser !== exp_r.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, m_axis_tuser);
        end
        if (m_axis_tdata[22:0] !== exp_r.blk_start) begin
          errors++;
          $display("%0t: alloc start exp %0d got %0d", $time, exp_r.blk_start,
                   m_axis_tdata[22:0]);
        end
        if (m_axis_tdata[45:23] !== exp_r.blk_length) begin
          errors++;
          $display("%0t: alloc length exp %0d got %0d", $time, exp_r.blk_length,
                   m_axis_tdata[45:23]);
        end
        if (m_axis_tdata[68:46] !== exp_r.free_bytes) begin
          errors++;
          $display("%0t: free_bytes exp %0d got %0d", $time, exp_r.free_bytes,
                   m_axis_tdata[68:46]);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || (req_q.size() == 0 && result_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, result_q.size());
      $display("FAIL best_fit_extent_allocator_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== best_fit_extent_allocator_top.f =====
rtl/core/bfea_pkg.sv
rtl/core/bfea_ram.sv
rtl/core/bfea_datapath.sv
rtl/core/bfea_ctrl.sv
rtl/core/best_fit_extent_allocator_top.sv
verif/tb_best_fit_extent_allocator_top.sv
